/* hw/rtl/gvct_pkg.sv */
// Shared constants, types and helper function of the vertex connectivity tester.
package gvct_pkg;

    localparam int MAX_VERTICES = 11;
    localparam int EDGE_BITS    = 36;
    localparam int COUNT_W      = 4;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [1:0]         fail_kind_t;

    localparam fail_kind_t FAIL_NONE      = 2'd0;
    localparam fail_kind_t FAIL_DEGREE    = 2'd1;
    localparam fail_kind_t FAIL_SEPARATOR = 2'd2;

    // Status of one reachability expansion step.
    typedef struct packed {
        logic grew;
        logic covers;
    } reach_stat_t;

    function automatic count_t popcount(input logic [MAX_VERTICES-1:0] x);
        count_t c;
        c = '0;
        for (int b = 0; b < MAX_VERTICES; b++)
        begin
            c = c + count_t'(x[b]);
        end
        return c;
    endfunction

endpackage

/* hw/rtl/gvct_adj_decode.sv */
// Decoder from the missing-edge mask to the rows of the adjacency matrix.
module gvct_adj_decode
    import gvct_pkg::*;
#(
    parameter int VERTICES = 9
)
(
    input  logic [EDGE_BITS-1:0]                   missing_edges,
    output logic [VERTICES-1:0][VERTICES-1:0]      adj
);

    for (genvar gi = 0; gi < VERTICES; gi++)
    begin : g_row
        for (genvar gj = 0; gj < VERTICES; gj++)
        begin : g_col
            if (gi == gj)
            begin : g_diag
                assign adj[gi][gj] = 1'b0;
            end
            else
            begin : g_pair
                localparam int LO  = (gi < gj) ? gi : gj;
                localparam int HI  = (gi < gj) ? gj : gi;
                localparam int IDX = LO * VERTICES - (LO * (LO + 1)) / 2 + (HI - LO - 1);
                // Pairs past the end of the mask cannot be marked missing.
                if (IDX < EDGE_BITS)
                begin : g_in_mask
                    assign adj[gi][gj] = ~missing_edges[IDX];
                end
                else
                begin : g_beyond
                    assign adj[gi][gj] = 1'b1;
                end
            end
        end
    end

endmodule

/* hw/rtl/gvct_reach_unit.sv */
// Shared reachability unit: one breadth-first expansion step over the remaining vertices.
module gvct_reach_unit
    import gvct_pkg::*;
#(
    parameter int VERTICES = 9
)
(
    input  logic [VERTICES-1:0][VERTICES-1:0] adj,
    input  logic [VERTICES-1:0]               seen,
    input  logic [VERTICES-1:0]               rest,
    output logic [VERTICES-1:0]               reach,
    output reach_stat_t                       stat
);

    logic [VERTICES-1:0] nbrs;

    always_comb
    begin
        nbrs = '0;
        for (int v = 0; v < VERTICES; v++)
        begin
            if (seen[v])
            begin
                nbrs = nbrs | adj[v];
            end
        end
        reach       = seen | (nbrs & rest);
        stat.grew   = (reach != seen);
        stat.covers = (seen == rest);
    end

endmodule

/* hw/rtl/graph_vertex_connectivity_test_unit.sv */
// Top level of the k-vertex-connectivity tester for a small graph.
//
// Usage: present a graph as missing_edges (bit e removes the e-th vertex pair i<j in
// lexicographic order from the complete graph) and raise start. The word is taken
// at a rising edge where start is high and busy is low; busy then stays high until
// the answer is out. The answer appears on is_connected_enough and fail_kind, marked by
// done, which is high for exactly one cycle; the receiver cannot hold it off.
// min_connectivity_wr writes min_connectivity (k); use it only while idle (not enforced).
//
// The search checks the vertices one at a time in a degree phase, then sweeps over all
// 2**VERTICES deletion sets. Each set is visited in ST_SUBSET and, when it is small
// enough to test, followed by expansion steps of the shared reachability unit in
// ST_GROW until the reached set stops growing. A failure ends the search early.
// done is raised in the cycle after the last step, and busy falls with it, so a
// new word can be started while the previous answer is on the ports.
// Reset clears the sequencer and sets k to 5; no answer is pending after reset.
module graph_vertex_connectivity_test_unit
    import gvct_pkg::*;
#(
    parameter int VERTICES = 9
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [EDGE_BITS-1:0] missing_edges,
    input  logic                 min_connectivity_wr,
    input  logic [COUNT_W-1:0]   min_connectivity,
    output logic                 done,
    output logic                 is_connected_enough,
    output logic [1:0]           fail_kind
);

    localparam int VTX_W = $clog2(VERTICES);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DEGREE = 2'd1;
    localparam logic [1:0] ST_SUBSET = 2'd2;
    localparam logic [1:0] ST_GROW   = 2'd3;

    logic [1:0]                          state_reg, state_next;
    logic [VTX_W-1:0]                    vtx_reg, vtx_next;
    logic [VERTICES-1:0]                 subset_reg, subset_next;
    logic [VERTICES-1:0]                 seen_reg, seen_next;
    logic [VERTICES-1:0][VERTICES-1:0]   adj_reg, adj_next;
    count_t                              k_reg;
    logic                                done_reg, done_next;
    fail_kind_t                          kind_reg, kind_next;

    logic [VERTICES-1:0][VERTICES-1:0]   adj_dec;
    logic [VERTICES-1:0]                 rest;
    logic [VERTICES-1:0]                 reach;
    reach_stat_t                         stat;
    count_t                              set_size;
    count_t                              degree;
    logic                                rest_trivial;

    gvct_adj_decode #(
        .VERTICES (VERTICES)
    ) u_decode (
        .missing_edges (missing_edges),
        .adj           (adj_dec)
    );

    gvct_reach_unit #(
        .VERTICES (VERTICES)
    ) u_reach (
        .adj   (adj_reg),
        .seen  (seen_reg),
        .rest  (rest),
        .reach (reach),
        .stat  (stat)
    );

    assign rest         = ~subset_reg;
    assign set_size     = popcount(MAX_VERTICES'(subset_reg));
    assign degree       = popcount(MAX_VERTICES'(adj_reg[vtx_reg]));
    // An empty or single-vertex remainder is connected by definition.
    assign rest_trivial = ((rest & (rest - 1'b1)) == '0);

    always_comb
    begin
        state_next  = state_reg;
        vtx_next    = vtx_reg;
        subset_next = subset_reg;
        seen_next   = seen_reg;
        adj_next    = adj_reg;
        done_next   = 1'b0;
        kind_next   = kind_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    adj_next   = adj_dec;
                    vtx_next   = '0;
                    state_next = ST_DEGREE;
                end
            end
            ST_DEGREE:
            begin
                if (degree < k_reg)
                begin
                    done_next  = 1'b1;
                    kind_next  = FAIL_DEGREE;
                    state_next = ST_IDLE;
                end
                else if (vtx_reg == VTX_W'(VERTICES - 1))
                begin
                    subset_next = '0;
                    state_next  = ST_SUBSET;
                end
                else
                begin
                    vtx_next = vtx_reg + 1'b1;
                end
            end
            ST_SUBSET:
            begin
                if ((set_size < k_reg) && !rest_trivial)
                begin
                    seen_next  = rest & (~rest + 1'b1);
                    state_next = ST_GROW;
                end
                else if (&subset_reg)
                begin
                    done_next  = 1'b1;
                    kind_next  = FAIL_NONE;
                    state_next = ST_IDLE;
                end
                else
                begin
                    subset_next = subset_reg + 1'b1;
                end
            end
            ST_GROW:
            begin
                if (stat.grew)
                begin
                    seen_next = reach;
                end
                else if (!stat.covers)
                begin
                    done_next  = 1'b1;
                    kind_next  = FAIL_SEPARATOR;
                    state_next = ST_IDLE;
                end
                else if (&subset_reg)
                begin
                    done_next  = 1'b1;
                    kind_next  = FAIL_NONE;
                    state_next = ST_IDLE;
                end
                else
                begin
                    subset_next = subset_reg + 1'b1;
                    state_next  = ST_SUBSET;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            vtx_reg    <= '0;
            subset_reg <= '0;
            done_reg   <= 1'b0;
            kind_reg   <= FAIL_NONE;
            k_reg      <= count_t'(5);
        end
        else
        begin
            state_reg  <= state_next;
            vtx_reg    <= vtx_next;
            subset_reg <= subset_next;
            done_reg   <= done_next;
            kind_reg   <= kind_next;
            if (min_connectivity_wr)
            begin
                k_reg <= min_connectivity;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        adj_reg  <= adj_next;
        seen_reg <= seen_next;
    end

    assign busy                = (state_reg != ST_IDLE);
    assign done                = done_reg;
    assign fail_kind           = kind_reg;
    assign is_connected_enough = (kind_reg == FAIL_NONE);

endmodule

/* tb/graph_vertex_connectivity_test_unit_tb.sv */
// Self-checking testbench for the small-graph vertex connectivity tester.
`timescale 1ns / 1ps

module graph_vertex_connectivity_test_unit_tb
    import gvct_pkg::*;
();

    localparam int NV          = 9;
    localparam int STALL_LIMIT = 40000;
    localparam int DRAIN_WAIT  = 40;

    typedef enum logic [1:0] {ACT_GRAPH, ACT_SET_K, ACT_DRAIN} action_t;

    typedef struct {
        action_t              act;
        logic [EDGE_BITS-1:0] value;
        int unsigned          idle;
    } stim_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [EDGE_BITS-1:0] missing_edges = '0;
    logic                 min_connectivity_wr = 1'b0;
    logic [COUNT_W-1:0]   min_connectivity = count_t'(5);
    logic                 done;
    logic                 is_connected_enough;
    logic [1:0]           fail_kind;

    stim_t       pending[$];
    fail_kind_t  expected_kinds[$];
    int unsigned k_model = 5;
    int unsigned idle_left = 0;
    int          stall_cycles = 0;
    int          errors = 0;
    int          graphs_accepted = 0;
    int          pass_seen = 0;
    int          degree_seen = 0;
    int          separator_seen = 0;
    int          k_settings = 0;
    bit          steady_burst = 1'b0;

    graph_vertex_connectivity_test_unit #(.VERTICES(NV)) dut
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .missing_edges       (missing_edges),
        .min_connectivity_wr (min_connectivity_wr),
        .min_connectivity    (min_connectivity),
        .done                (done),
        .is_connected_enough (is_connected_enough),
        .fail_kind           (fail_kind)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Expected verdict for one graph under connectivity k.
    function automatic fail_kind_t predict_kind(input logic [EDGE_BITS-1:0] miss,
                                                input int unsigned k);
        logic [NV-1:0] adj [NV];
        logic [NV-1:0] full, rest, seen, prev, del;
        int            e;
        fail_kind_t    kind;
        kind = FAIL_NONE;
        full = '1;
        e = 0;
        for (int i = 0; i < NV; i++)
        begin
            adj[i] = full;
            adj[i][i] = 1'b0;
        end
        for (int i = 0; i < NV; i++)
        begin
            for (int j = i + 1; j < NV; j++)
            begin
                if (e < EDGE_BITS && miss[e])
                begin
                    adj[i][j] = 1'b0;
                    adj[j][i] = 1'b0;
                end
                e++;
            end
        end
        for (int i = 0; i < NV; i++)
        begin
            if ($countones(adj[i]) < k)
                kind = FAIL_DEGREE;
        end
        if (kind == FAIL_NONE && k > 0)
        begin
            for (int s = 0; s < (1 << NV) && kind == FAIL_NONE; s++)
            begin
                del = s[NV-1:0];
                rest = full & ~del;
                // Deletion sets that leave at most one vertex are connected by definition.
                if ($countones(del) <= k - 1 && (rest & (rest - 1'b1)) != '0)
                begin
                    seen = rest & (~rest + 1'b1);
                    do
                    begin
                        prev = seen;
                        for (int v = 0; v < NV; v++)
                        begin
                            if (prev[v])
                                seen = seen | (adj[v] & rest);
                        end
                    end while (seen != prev);
                    if (seen != rest)
                        kind = FAIL_SEPARATOR;
                end
            end
        end
        return kind;
    endfunction

    // Missing-edge mask that removes every edge between vertex sets a and b.
    function automatic logic [EDGE_BITS-1:0] cut_between(input logic [NV-1:0] a,
                                                         input logic [NV-1:0] b);
        logic [EDGE_BITS-1:0] m;
        int                   e;
        m = '0;
        e = 0;
        for (int i = 0; i < NV; i++)
        begin
            for (int j = i + 1; j < NV; j++)
            begin
                if ((a[i] && b[j]) || (a[j] && b[i]))
                    m[e] = 1'b1;
                e++;
            end
        end
        return m;
    endfunction

    function automatic void shuffle_vertices(output int order [NV]);
        int j, t;
        for (int i = 0; i < NV; i++)
            order[i] = i;
        for (int i = NV - 1; i > 0; i--)
        begin
            j = $urandom_range(i, 0);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
    endfunction

    // Complete graph less all edges between sides A and B, split by a vertex cut S of at most k.
    function automatic logic [EDGE_BITS-1:0] gen_separated(input int unsigned k);
        int                   order [NV];
        int                   s_size, a_size;
        logic [NV-1:0]        a, b;
        logic [EDGE_BITS-1:0] m;
        shuffle_vertices(order);
        s_size = $urandom_range(k > NV - 2 ? NV - 2 : k, 0);
        a_size = $urandom_range(NV - s_size - 1, 1);
        a = '0;
        b = '0;
        for (int i = 0; i < NV; i++)
        begin
            if (i >= s_size && i < s_size + a_size)
                a[order[i]] = 1'b1;
            else if (i >= s_size + a_size)
                b[order[i]] = 1'b1;
        end
        m = cut_between(a, b);
        if ($urandom_range(1, 0) == 1)
            m[$urandom_range(EDGE_BITS - 1, 0)] = 1'b1;
        return m;
    endfunction

    // One vertex left with degree k or k-1 (clamped to 0..NV-1), everything else complete.
    function automatic logic [EDGE_BITS-1:0] gen_low_degree(input int unsigned k);
        int            order [NV];
        int            v, d, n;
        logic [NV-1:0] drop;
        shuffle_vertices(order);
        v = $urandom_range(NV - 1, 0);
        d = int'(k) - int'($urandom_range(1, 0));
        if (d < 0)
            d = 0;
        if (d > NV - 1)
            d = NV - 1;
        n = (NV - 1) - d;
        drop = '0;
        for (int i = 0; i < NV && n > 0; i++)
        begin
            if (order[i] != v)
            begin
                drop[order[i]] = 1'b1;
                n--;
            end
        end
        return cut_between(NV'(1) << v, drop);
    endfunction

    function automatic logic [EDGE_BITS-1:0] gen_random_graph(input int unsigned k);
        logic [EDGE_BITS-1:0] m;
        int                   r, n;
        r = $urandom_range(99, 0);
        m = '0;
        if (r < 15)
            m = EDGE_BITS'({$urandom, $urandom});
        else if (r < 45)
        begin
            n = ($urandom_range(9, 0) == 0) ? $urandom_range(14, 6) : $urandom_range(5, 0);
            repeat (n) m[$urandom_range(EDGE_BITS - 1, 0)] = 1'b1;
        end
        else if (r < 80)
            m = gen_separated(k);
        else
            m = gen_low_degree(k);
        return m;
    endfunction

    task automatic queue_graph(input logic [EDGE_BITS-1:0] m);
        stim_t       item;
        int unsigned r;
        r = $urandom_range(99, 0);
        item.act = ACT_GRAPH;
        item.value = m;
        if (steady_burst || r < 60)
            item.idle = 0;
        else if (r < 90)
            item.idle = $urandom_range(4, 1);
        else if (r < 98)
            item.idle = $urandom_range(40, 5);
        else
            item.idle = $urandom_range(6000, 200);
        pending.insert(pending.size(), item);
    endtask

    task automatic queue_control(input action_t act, input int unsigned value);
        stim_t item;
        item.act = act;
        item.value = EDGE_BITS'(value);
        item.idle = 0;
        pending.insert(pending.size(), item);
    endtask

    // Driver: offers one word at a time and pauses for register writes and drains.
    always @(posedge clk)
    begin : driver
        stim_t head;
        logic  next_start;
        logic  next_wr;
        if (rst_n)
        begin
            next_start = start;
            next_wr = 1'b0;
            if (start && !busy)
            begin
                expected_kinds.insert(expected_kinds.size(),
                                      predict_kind(missing_edges, k_model));
                graphs_accepted++;
                next_start = 1'b0;
            end
            if (!next_start)
            begin
                if (idle_left > 0)
                    idle_left--;
                else if (pending.size() > 0)
                begin
                    head = pending[0];
                    case (head.act)
                        ACT_GRAPH:
                        begin
                            missing_edges <= head.value;
                            next_start = 1'b1;
                            idle_left = head.idle;
                            void'(pending.pop_front());
                        end
                        ACT_SET_K:
                        begin
                            if (expected_kinds.size() == 0)
                            begin
                                min_connectivity <= head.value[COUNT_W-1:0];
                                k_model = 32'(head.value[COUNT_W-1:0]);
                                next_wr = 1'b1;
                                k_settings++;
                                void'(pending.pop_front());
                            end
                        end
                        ACT_DRAIN:
                        begin
                            if (expected_kinds.size() == 0)
                                void'(pending.pop_front());
                        end
                        default:
                            void'(pending.pop_front());
                    endcase
                end
            end
            start <= next_start;
            min_connectivity_wr <= next_wr;
        end
    end

    always @(posedge clk)
    begin : monitor
        fail_kind_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_kinds.size() == 0)
            begin
                $error("unexpected word: is_connected_enough=%0b fail_kind=%0d",
                       is_connected_enough, fail_kind);
                errors++;
            end
            else
            begin
                want = expected_kinds.pop_front();
                if (is_connected_enough !== (want == FAIL_NONE))
                begin
                    $error("is_connected_enough: expected %0b, got %0b",
                           want == FAIL_NONE, is_connected_enough);
                    errors++;
                end
                if (fail_kind !== want)
                begin
                    $error("fail_kind: expected %0d, got %0d", want, fail_kind);
                    errors++;
                end
                case (fail_kind)
                    FAIL_NONE:      pass_seen++;
                    FAIL_DEGREE:    degree_seen++;
                    FAIL_SEPARATOR: separator_seen++;
                    default:        ;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : stimulus
        int unsigned k_list [11];
        int          count;
        k_list = '{5, 1, 8, 2, 0, 7, 3, 15, 4, 6, 9};

        // Directed graphs under the reset value of k (5).
        queue_graph('0);
        queue_graph('1);
        queue_graph(EDGE_BITS'(1));
        queue_graph(EDGE_BITS'(1) << (EDGE_BITS - 1));
        queue_graph(36'h5_5555_5555);
        queue_graph(36'hA_AAAA_AAAA);
        queue_graph(cut_between(9'h001, 9'h1FE));
        queue_graph(cut_between(9'h010, 9'h00E));
        queue_graph(cut_between(9'h010, 9'h00F));
        queue_graph(cut_between(9'h030, 9'h1C0));
        queue_graph(cut_between(9'h060, 9'h180));
        queue_graph(cut_between(9'h038, 9'h1C0));
        queue_graph(cut_between(9'h01F, 9'h1E0));
        queue_graph(cut_between(9'h00F, 9'h1E0));

        foreach (k_list[p])
        begin
            queue_control(ACT_SET_K, k_list[p]);
            queue_graph('0);
            queue_graph('1);
            count = (k_list[p] == 0 || k_list[p] >= NV) ? 30 : 115;
            for (int n = 0; n < count; n++)
            begin
                if (n % 40 == 0)
                    steady_burst = ($urandom_range(2, 0) == 0);
                if (n == count / 2)
                    queue_control(ACT_DRAIN, 0);
                queue_graph(gen_random_graph(k_list[p]));
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (!(pending.size() == 0 && !start && expected_kinds.size() == 0)
               && stall_cycles < STALL_LIMIT)
            @(posedge clk);
        if (stall_cycles < STALL_LIMIT)
            repeat (DRAIN_WAIT) @(posedge clk);

        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("** graph_vertex_connectivity_test_unit: FAILED **");
        end
        else
        begin
            $display("Checked %0d graphs over %0d settings of k from 0 to 15.",
                     graphs_accepted, k_settings);
            $display("Verdicts: %0d connected enough, %0d low degree, %0d small separator.",
                     pass_seen, degree_seen, separator_seen);
            if (errors == 0)
                $display("** graph_vertex_connectivity_test_unit: PASSED **");
            else
                $display("** graph_vertex_connectivity_test_unit: FAILED **");
        end
        $finish;
    end

endmodule
